FILE: hdl/i2cbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbm_pkg
// types, codes and reset values shared by the tick-driven i2c bit master
// ----------------------------------------------------------------------------
package i2cbm_pkg;

	localparam int unsigned HALF_W  = 16;
	localparam int unsigned TOUT_W  = 8;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned BIDX_W  = 4;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned IN_W    = 16;
	localparam int unsigned OUT_W   = 16;
	localparam int unsigned CIDX_W  = 1;

	localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 16'd5;
	localparam logic [TOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;
	localparam logic [BIDX_W-1:0] BITS_PER_BYTE   = 4'd8;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_HALF_PERIOD = 1'b0;
	localparam logic [CIDX_W-1:0] REG_ACK_TIMEOUT = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		K_TICK  = 3'd0,
		K_START = 3'd1,
		K_STOP  = 3'd2,
		K_WRITE = 3'd3,
		K_READ  = 3'd4,
		K_SACK  = 3'd5,
		K_RACK  = 3'd6,
		K_PROBE = 3'd7
	} kind_t;

	typedef enum logic [20:0] {
		P_IDLE = 21'h000001,
		P_ST0  = 21'h000002,
		P_ST1  = 21'h000004,
		P_ST2  = 21'h000008,
		P_ST3  = 21'h000010,
		P_ST4  = 21'h000020,
		P_SP0  = 21'h000040,
		P_SP1  = 21'h000080,
		P_SP2  = 21'h000100,
		P_WB0  = 21'h000200,
		P_WB1  = 21'h000400,
		P_WB2  = 21'h000800,
		P_RD0  = 21'h001000,
		P_RB1  = 21'h002000,
		P_RB2  = 21'h004000,
		P_SA0  = 21'h008000,
		P_SA1  = 21'h010000,
		P_SA2  = 21'h020000,
		P_RA0  = 21'h040000,
		P_RA1  = 21'h080000,
		P_RA2  = 21'h100000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		kind_t               cmd;
		logic [HALF_W-1:0]   dly;
		logic [BIDX_W-1:0]   bidx;
		logic [BYTE_W-1:0]   shb;
		logic [TOUT_W-1:0]   wcnt;
		logic                scl;
		logic                sda;
		logic                sda_rel;
		logic                fail;
		logic [BYTE_W-1:0]   rbyte;
	} mst_state_t;

	localparam mst_state_t MST_RST = '{
		phase:   P_IDLE,
		cmd:     K_TICK,
		dly:     '0,
		bidx:    '0,
		shb:     '0,
		wcnt:    '0,
		scl:     1'b0,
		sda:     1'b0,
		sda_rel: 1'b0,
		fail:    1'b0,
		rbyte:   '0
	};

endpackage
`default_nettype wire

FILE: hdl/i2c_bit_level_master.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_bit_level_master: tick-driven i2c master, one input beat per bus tick
// result: the result beat of a tick is registered and presented in the cycle after it is taken
// throughput: one beat per cycle while the result side keeps taking beats, the output register frees as it is taken
// reset: bus state idle, scl/sda low and driven, registers at their defaults
// ----------------------------------------------------------------------------
module i2c_bit_level_master
	import i2cbm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// tick / command channel
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,  // data[7:0], ack_level[8], sda_in[9], zero pad
	input  wire logic [KIND_W-1:0] s_tuser,  // kind[2:0]
	// result channel
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata,  // scl[0], sda_out[1], sda_is_input[2],
	                                         // busy_res[3], done_res[4], read_data[12:5],
	                                         // ack_fail[13], rejected[14], zero pad
	// configuration write channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [HALF_W-1:0] cfg_data
);

	// configuration registers
	logic [HALF_W-1:0] half_q;
	logic [TOUT_W-1:0] tout_q;

	// bus state and result register
	mst_state_t        st_q;
	mst_state_t        nxt;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic              accept;
	logic [HALF_W-1:0] dly_load;
	logic [HALF_W-1:0] dly_dec;
	kind_t             kind;
	logic              done;
	logic              rej;
	logic              do_enter;
	logic              do_poll;
	phase_t            tgt;
	phase_t            poll_tgt;
	logic              probe;
	logic [BYTE_W-1:0] in_data;
	logic              in_ackl;
	logic              in_sda;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign kind    = kind_t'(s_tuser);
	assign in_data = s_tdata[7:0];
	assign in_ackl = s_tdata[8];
	assign in_sda  = s_tdata[9];

	// a zero half period still spaces pin changes by one tick
	assign dly_load = (half_q == '0) ? HALF_W'(1) : half_q;
	assign probe    = (st_q.cmd == K_PROBE);

	// pin action taken on entering a phase, the delay reloads every time
	function automatic mst_state_t enter_phase(input mst_state_t s, input phase_t p,
		input logic [HALF_W-1:0] d, input logic sda_smp);
		mst_state_t r;
		r = s;
		r.phase = p;
		r.dly = d;
		case (p)
			P_ST0, P_SP0: begin
				r.sda_rel = 1'b0;
				r.sda = 1'b0;
			end
			P_ST1, P_SP1, P_WB1, P_RB1, P_SA1: r.scl = 1'b1;
			P_ST2, P_SP2: r.sda = 1'b1;
			P_ST3: r.sda = 1'b0;
			P_ST4, P_SA2: r.scl = 1'b0;
			P_WB2: begin
				r.scl = 1'b0;
				r.bidx = r.bidx + 1'b1;
			end
			P_WB0: begin
				r.sda_rel = 1'b0;
				r.scl = 1'b0;
				r.sda = r.shb[BYTE_W-1];
				r.shb = {r.shb[BYTE_W-2:0], 1'b0};
			end
			P_RD0: begin
				r.sda_rel = 1'b1;
				r.sda = 1'b1;
				r.bidx = '0;
				r.shb = '0;
			end
			P_RB2: begin
				r.shb = {r.shb[BYTE_W-2:0], sda_smp};
				r.scl = 1'b0;
				r.bidx = r.bidx + 1'b1;
			end
			P_SA0: begin
				r.sda_rel = 1'b0;
				r.scl = 1'b0;
				r.sda = r.shb[0];
			end
			P_RA0: begin
				r.sda_rel = 1'b1;
				r.sda = 1'b1;
				r.scl = 1'b1;
				r.wcnt = '0;
			end
			P_RA2: begin
				r.scl = 1'b0;
				r.fail = 1'b0;
			end
			default: r = r;
		endcase
		return r;
	endfunction

	// one tick of the bus sequencer
	always_comb begin
		nxt      = st_q;
		done     = 1'b0;
		rej      = 1'b0;
		do_enter = 1'b0;
		do_poll  = 1'b0;
		tgt      = P_IDLE;
		poll_tgt = P_IDLE;
		dly_dec  = (st_q.dly != '0) ? st_q.dly - 1'b1 : '0;

		if (st_q.phase == P_IDLE) begin
			// idle: a nonzero kind launches a command
			if (kind != K_TICK) begin
				nxt.cmd  = kind;
				do_enter = 1'b1;
				case (kind)
					K_START: tgt = P_ST0;
					K_STOP:  tgt = P_SP0;
					K_WRITE: begin
						nxt.shb  = in_data;
						nxt.bidx = '0;
						tgt      = P_WB0;
					end
					K_READ:  tgt = P_RD0;
					K_SACK: begin
						nxt.shb = {{(BYTE_W-1){1'b0}}, in_ackl};
						tgt     = P_SA0;
					end
					K_RACK:  tgt = P_RA0;
					default: begin
						// probe: address with write bit zero goes out unchanged
						nxt.shb = in_data;
						tgt     = P_ST0;
					end
				endcase
			end
		end else begin
			rej = (kind != K_TICK);
			if (st_q.phase == P_RA1) begin
				do_poll = 1'b1;
			end else begin
				nxt.dly = dly_dec;
				if (dly_dec == '0) begin
					do_enter = 1'b1;
					case (st_q.phase)
						P_ST4: begin
							if (probe) begin
								nxt.bidx = '0;
								tgt      = P_WB0;
							end else begin
								do_enter = 1'b0;
							end
						end
						P_WB2: begin
							if (st_q.bidx < BITS_PER_BYTE) begin
								tgt = P_WB0;
							end else if (probe) begin
								tgt = P_RA0;
							end else begin
								do_enter = 1'b0;
							end
						end
						P_RB2: begin
							if (st_q.bidx < BITS_PER_BYTE) begin
								tgt = P_RB1;
							end else begin
								nxt.rbyte = st_q.shb;
								do_enter  = 1'b0;
							end
						end
						P_RA2: begin
							if (probe) begin
								tgt = P_SP0;
							end else begin
								do_enter = 1'b0;
							end
						end
						P_RD0: tgt = P_RB1;
						P_ST0: tgt = P_ST1;
						P_ST1: tgt = P_ST2;
						P_ST2: tgt = P_ST3;
						P_ST3: tgt = P_ST4;
						P_SP0: tgt = P_SP1;
						P_SP1: tgt = P_SP2;
						P_WB0: tgt = P_WB1;
						P_WB1: tgt = P_WB2;
						P_RB1: tgt = P_RB2;
						P_SA0: tgt = P_SA1;
						P_SA1: tgt = P_SA2;
						P_RA0: tgt = P_RA1;
						default: do_enter = 1'b0;
					endcase
					if (!do_enter) begin
						nxt.phase = P_IDLE;
						done      = 1'b1;
					end
				end
			end
		end

		if (do_enter) begin
			nxt = enter_phase(nxt, tgt, dly_load, in_sda);
		end

		// acknowledge poll: low sample wins, then timeout, else keep counting
		if (do_poll || (do_enter && tgt == P_RA1)) begin
			if (!in_sda) begin
				poll_tgt = P_RA2;
				nxt = enter_phase(nxt, poll_tgt, dly_load, in_sda);
			end else if (nxt.wcnt >= tout_q) begin
				poll_tgt = P_SP0;
				nxt.fail = 1'b1;
				nxt = enter_phase(nxt, poll_tgt, dly_load, in_sda);
			end else begin
				nxt.wcnt = nxt.wcnt + 1'b1;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RST;
			tout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HALF_PERIOD: half_q <= cfg_data;
				REG_ACK_TIMEOUT: tout_q <= cfg_data[TOUT_W-1:0];
				default: half_q <= half_q;
			endcase
		end
	end

	// sequencer state advances once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MST_RST;
		end else if (accept) begin
			st_q <= nxt;
		end
	end

	// result register, refilled while the previous beat is being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {1'b0, rej, nxt.fail, nxt.rbyte, done,
				(nxt.phase != P_IDLE), nxt.sda_rel, nxt.sda, nxt.scl};
		end
	end

`ifndef SYNTHESIS
	// a finishing tick never reports the bus as still busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[4] |-> !m_tdata_q[3])
		else $error("done reported together with busy");

	// bit counter never runs past one byte
	a_bidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bidx <= BITS_PER_BYTE)
		else $error("bit index beyond byte length");

	// a command taken while idle always leaves the idle phase
	a_cmd_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept && st_q.phase == P_IDLE && s_tuser != K_TICK |=> st_q.phase != P_IDLE)
		else $error("command accepted while idle did not start");
`endif

endmodule
`default_nettype wire
